[hdl/tea_pkg.sv]
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, register codes and the round mixing function of the TEA unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tea_pkg;

    localparam logic [31:0] DELTA = 32'h9e3779b9;

    // Key register indexes (paddr[3:2])
    localparam logic [1:0] REG_KEY0 = 2'd0;
    localparam logic [1:0] REG_KEY1 = 2'd1;
    localparam logic [1:0] REG_KEY2 = 2'd2;
    localparam logic [1:0] REG_KEY3 = 2'd3;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } t_key;

    typedef struct packed {
        logic        mode;
        logic [31:0] a;
        logic [31:0] b;
    } t_blk;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_pair;

    function automatic logic [31:0] mix_word(input logic [31:0] x,
                                             input logic [31:0] sum,
                                             input logic [31:0] ka,
                                             input logic [31:0] kb);
        return (x << 4) + (ka ^ x) + (sum ^ (x >> 5)) + kb;
    endfunction

endpackage

`default_nettype wire

[hdl/tea_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tea_cfg_regs
// APB-style register file holding the four 32-bit key words.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_cfg_regs (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output tea_pkg::t_key           o_key
);

    tea_pkg::t_key r_key;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                tea_pkg::REG_KEY0: r_key.k0 <= pwdata;
                tea_pkg::REG_KEY1: r_key.k1 <= pwdata;
                tea_pkg::REG_KEY2: r_key.k2 <= pwdata;
                tea_pkg::REG_KEY3: r_key.k3 <= pwdata;
                default: r_key <= r_key;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tea_pkg::REG_KEY0: prdata = r_key.k0;
            tea_pkg::REG_KEY1: prdata = r_key.k1;
            tea_pkg::REG_KEY2: prdata = r_key.k2;
            tea_pkg::REG_KEY3: prdata = r_key.k3;
            default:           prdata = '0;
        endcase
    end

    assign o_key = r_key;

endmodule

`default_nettype wire

[hdl/tea_half_round.sv]
// ----------------------------------------------------------------------------
// tea_half_round
// One registered half-round of the cipher, encrypt or decrypt per item.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_half_round #(
    parameter int unsigned ROUNDS = 32,
    parameter int unsigned STEP   = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire tea_pkg::t_blk  i_data,
    input  wire tea_pkg::t_key  i_key,
    output logic                o_valid,
    output tea_pkg::t_blk       o_data
);

    localparam int unsigned RND      = STEP / 2;
    localparam logic        ODD      = (STEP % 2) == 1;
    localparam logic [63:0] ENC_SUMW = 64'(RND + 1) * 64'(tea_pkg::DELTA);
    localparam logic [63:0] DEC_SUMW = 64'(ROUNDS - RND) * 64'(tea_pkg::DELTA);
    localparam logic [31:0] ENC_SUM  = ENC_SUMW[31:0];
    localparam logic [31:0] DEC_SUM  = DEC_SUMW[31:0];

    logic          r_valid;
    tea_pkg::t_blk r_data;
    tea_pkg::t_blk n_data;
    logic          dec;
    logic          use_a;
    logic [31:0]   mx_in;
    logic [31:0]   mx_sum;
    logic [31:0]   mx_ka;
    logic [31:0]   mx_kb;
    logic [31:0]   mx;

    assign dec    = (i_data.mode == tea_pkg::MODE_DEC);
    // Encrypt updates a on even steps; decrypt updates b on even steps
    assign use_a  = ODD ^ dec;
    assign mx_in  = use_a ? i_data.a : i_data.b;
    assign mx_sum = dec ? DEC_SUM : ENC_SUM;
    assign mx_ka  = use_a ? i_key.k2 : i_key.k0;
    assign mx_kb  = use_a ? i_key.k3 : i_key.k1;
    assign mx     = tea_pkg::mix_word(mx_in, mx_sum, mx_ka, mx_kb);

    always_comb begin
        n_data = i_data;
        if (use_a) begin
            n_data.b = dec ? (i_data.b - mx) : (i_data.b + mx);
        end else begin
            n_data.a = dec ? (i_data.a - mx) : (i_data.a + mx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[hdl/tea_out_skid.sv]
// ----------------------------------------------------------------------------
// tea_out_skid
// Output register with a skid entry; freezes the pipeline when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_out_skid (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire tea_pkg::t_pair i_data,
    input  wire logic           i_stall,
    output logic                o_en,
    output logic                o_valid,
    output tea_pkg::t_pair      o_data
);

    logic           r_ov;
    logic           r_sv;
    tea_pkg::t_pair r_out;
    tea_pkg::t_pair r_skid;
    logic           out_take;
    logic           out_free;

    assign out_take = r_ov && !i_stall;
    assign out_free = !r_ov || out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            // pipeline frozen: drain skid into output on transfer
            if (out_take) begin
                r_sv <= 1'b0;
            end
        end else if (out_free) begin
            r_ov <= i_valid;
        end else if (i_valid) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (out_free) begin
            r_out <= i_data;
        end else if (i_valid) begin
            r_skid <= i_data;
        end
    end

    assign o_en    = !r_sv;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry full while output register empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv && !i_stall |=> !r_sv && r_ov && (o_data == $past(r_skid)))
        else $error("skid entry did not move to output on transfer");

    a_skid_catches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sv && r_ov && i_stall && i_valid |=> r_sv && $stable(r_out))
        else $error("item leaving pipeline under stall not captured");

endmodule

`default_nettype wire

[hdl/tea_block_cipher_unit.sv]
// ----------------------------------------------------------------------------
// tea_block_cipher_unit
// TEA encrypt/decrypt of 64-bit blocks, one half-round per pipeline stage.
// Each block passes the 2*ROUNDS half-round stage registers and then the
// output register. Throughput: one block per cycle while the pipeline is not
// frozen by a stall; the output register has one skid entry.
// Reset clears all stage valid bits, the output and skid valids and the keys.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_block_cipher_unit #(
    parameter int unsigned ROUNDS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [31:0] i_block_low,
    input  wire logic [31:0] i_block_high,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_out_low,
    output logic [31:0]      o_out_high,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned STEPS = 2 * ROUNDS;

    tea_pkg::t_key  key;
    tea_pkg::t_blk  s_data  [0:STEPS];
    logic           s_valid [0:STEPS];
    tea_pkg::t_pair last_pair;
    tea_pkg::t_pair out_pair;
    logic           pipe_en;

    tea_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_key   (key)
    );

    assign s_valid[0]     = i_valid;
    assign s_data[0].mode = i_mode;
    assign s_data[0].a    = i_block_low;
    assign s_data[0].b    = i_block_high;

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        tea_half_round #(
            .ROUNDS (ROUNDS),
            .STEP   (k)
        ) u_hr (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_valid (s_valid[k]),
            .i_data  (s_data[k]),
            .i_key   (key),
            .o_valid (s_valid[k+1]),
            .o_data  (s_data[k+1])
        );
    end

    assign last_pair.a = s_data[STEPS].a;
    assign last_pair.b = s_data[STEPS].b;

    tea_out_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid[STEPS]),
        .i_data  (last_pair),
        .i_stall (i_stall),
        .o_en    (pipe_en),
        .o_valid (o_valid),
        .o_data  (out_pair)
    );

    // hold the input side whenever the pipeline is frozen
    assign o_stall    = !pipe_en;
    assign o_out_low  = out_pair.a;
    assign o_out_high = out_pair.b;

endmodule

`default_nettype wire
